FILE: hdl/rc4_pkg.sv
// Shared constants, codes and types for the RC4 stream cipher block.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int SBOX_DEPTH        = 256;
  localparam int KEY_LEN_W         = 9;
  localparam int KEY_MAX_BYTES_DEF = 256;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  // operation codes on the input channel
  localparam logic [1:0] OP_KEY_WRITE = 2'd0;
  localparam logic [1:0] OP_START     = 2'd1;
  localparam logic [1:0] OP_DATA      = 2'd2;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_FILL = 12'b0000_0000_0010,
    ST_K0   = 12'b0000_0000_0100,
    ST_K1   = 12'b0000_0000_1000,
    ST_K2   = 12'b0000_0001_0000,
    ST_K3   = 12'b0000_0010_0000,
    ST_D0   = 12'b0000_0100_0000,
    ST_D1   = 12'b0000_1000_0000,
    ST_D2   = 12'b0001_0000_0000,
    ST_D3   = 12'b0010_0000_0000,
    ST_D4   = 12'b0100_0000_0000,
    ST_D5   = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/rc4_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module rc4_ram #(
  parameter int DEPTH = rc4_pkg::SBOX_DEPTH,
  parameter int AW    = 8,
  parameter int DW    = rc4_pkg::BYTE_W
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/rc4_ctrl.sv
// RC4 sequencer: identity fill, key schedule, keystream steps and the shared byte adder.
`default_nettype none

module rc4_ctrl #(
  parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF,
  parameter int KIW           = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [7:0]                       in_key_index,
  input  wire logic [rc4_pkg::BYTE_W-1:0]       in_key_byte,
  input  wire logic [rc4_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0]    key_length,
  // result toward the output register
  input  wire logic                             res_ready,
  output rc4_pkg::res_t                         res,
  // permutation memory
  output logic                                  sbox_wr_en,
  output logic [7:0]                            sbox_wr_addr,
  output logic [rc4_pkg::BYTE_W-1:0]            sbox_wr_data,
  output logic                                  sbox_rd_en,
  output logic [7:0]                            sbox_rd_addr,
  input  wire logic [rc4_pkg::BYTE_W-1:0]       sbox_rd_data,
  // key memory
  output logic                                  key_wr_en,
  output logic [KIW-1:0]                        key_wr_addr,
  output logic [rc4_pkg::BYTE_W-1:0]            key_wr_data,
  output logic                                  key_rd_en,
  output logic [KIW-1:0]                        key_rd_addr,
  input  wire logic [rc4_pkg::BYTE_W-1:0]       key_rd_data
);

  localparam int LW = $clog2(KEY_MAX_BYTES + 1);

  rc4_pkg::state_t state_r, state_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [KIW-1:0]  kpos_r, kpos_nxt;
  logic [7:0]      i_r, i_nxt;
  logic [7:0]      j_r, j_nxt;
  logic [7:0]      si_r, si_nxt;
  logic [7:0]      sj_r, sj_nxt;
  logic [7:0]      data_r, data_nxt;
  logic            sched_r, sched_nxt;

  logic [7:0]      add_a, add_b, add_c, add_y;
  logic [LW-1:0]   len_eff;
  logic [LW-1:0]   kpos_inc;
  logic            accept;

  // effective key length: zero acts as one, saturates at the store depth
  always_comb begin
    if (key_length == '0) begin
      len_eff = LW'(1);
    end else if (key_length > rc4_pkg::KEY_LEN_W'(KEY_MAX_BYTES)) begin
      len_eff = LW'(KEY_MAX_BYTES);
    end else begin
      len_eff = LW'(key_length);
    end
  end

  assign kpos_inc = LW'(kpos_r) + LW'(1);

  assign in_stall = (state_r != rc4_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // key store writes straight from the channel
  assign key_wr_en   = accept && (in_operation == rc4_pkg::OP_KEY_WRITE) &&
                       ({1'b0, in_key_index} < 9'(KEY_MAX_BYTES));
  assign key_wr_addr = in_key_index[KIW-1:0];
  assign key_wr_data = in_key_byte;
  assign key_rd_en   = (state_r == rc4_pkg::ST_K0);
  assign key_rd_addr = kpos_r;

  // shared byte adder
  assign add_y = add_a + add_b + add_c;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    kpos_nxt     = kpos_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    data_nxt     = data_r;
    sched_nxt    = sched_r;
    add_a        = '0;
    add_b        = '0;
    add_c        = '0;
    sbox_wr_en   = 1'b0;
    sbox_wr_addr = '0;
    sbox_wr_data = '0;
    sbox_rd_en   = 1'b0;
    sbox_rd_addr = '0;
    res.valid    = 1'b0;
    res.data     = data_r ^ sbox_rd_data;

    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == rc4_pkg::OP_START) begin
            sched_nxt = 1'b1;
            cnt_nxt   = '0;
            kpos_nxt  = '0;
            j_nxt     = '0;
            state_nxt = rc4_pkg::ST_FILL;
          end else if (in_operation == rc4_pkg::OP_DATA) begin
            data_nxt  = in_data_byte;
            state_nxt = rc4_pkg::ST_D0;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        sbox_wr_en   = 1'b1;
        sbox_wr_addr = cnt_r;
        sbox_wr_data = cnt_r;
        cnt_nxt      = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          state_nxt = sched_r ? rc4_pkg::ST_K0 : rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_K0: begin
        sbox_rd_en   = 1'b1;
        sbox_rd_addr = cnt_r;
        state_nxt    = rc4_pkg::ST_K1;
      end
      rc4_pkg::ST_K1: begin
        add_a        = j_r;
        add_b        = sbox_rd_data;
        add_c        = key_rd_data;
        j_nxt        = add_y;
        si_nxt       = sbox_rd_data;
        sbox_rd_en   = 1'b1;
        sbox_rd_addr = add_y;
        state_nxt    = rc4_pkg::ST_K2;
      end
      rc4_pkg::ST_K2: begin
        sbox_wr_en   = 1'b1;
        sbox_wr_addr = cnt_r;
        sbox_wr_data = sbox_rd_data;
        state_nxt    = rc4_pkg::ST_K3;
      end
      rc4_pkg::ST_K3: begin
        sbox_wr_en   = 1'b1;
        sbox_wr_addr = j_r;
        sbox_wr_data = si_r;
        cnt_nxt      = cnt_r + 8'd1;
        kpos_nxt     = (kpos_inc == len_eff) ? '0 : kpos_inc[KIW-1:0];
        if (cnt_r == 8'hFF) begin
          i_nxt     = '0;
          j_nxt     = '0;
          sched_nxt = 1'b0;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_K0;
        end
      end
      rc4_pkg::ST_D0: begin
        add_a        = i_r;
        add_b        = 8'd1;
        i_nxt        = add_y;
        sbox_rd_en   = 1'b1;
        sbox_rd_addr = add_y;
        state_nxt    = rc4_pkg::ST_D1;
      end
      rc4_pkg::ST_D1: begin
        add_a        = j_r;
        add_b        = sbox_rd_data;
        j_nxt        = add_y;
        si_nxt       = sbox_rd_data;
        sbox_rd_en   = 1'b1;
        sbox_rd_addr = add_y;
        state_nxt    = rc4_pkg::ST_D2;
      end
      rc4_pkg::ST_D2: begin
        sj_nxt       = sbox_rd_data;
        sbox_wr_en   = 1'b1;
        sbox_wr_addr = i_r;
        sbox_wr_data = sbox_rd_data;
        state_nxt    = rc4_pkg::ST_D3;
      end
      rc4_pkg::ST_D3: begin
        sbox_wr_en   = 1'b1;
        sbox_wr_addr = j_r;
        sbox_wr_data = si_r;
        state_nxt    = rc4_pkg::ST_D4;
      end
      rc4_pkg::ST_D4: begin
        add_a        = si_r;
        add_b        = sj_r;
        sbox_rd_en   = 1'b1;
        sbox_rd_addr = add_y;
        state_nxt    = rc4_pkg::ST_D5;
      end
      rc4_pkg::ST_D5: begin
        // keystream byte sits in the read register until the result is taken
        if (res_ready) begin
          res.valid = 1'b1;
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_FILL;  // identity fill after reset
      cnt_r   <= '0;
      kpos_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      sched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kpos_r  <= kpos_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      sched_r <= sched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: config register, output register, memories.
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer:
//     in_operation = key write : in_key_byte goes to key store slot in_key_index
//                    start     : identity fill plus the 256-step key schedule
//                    data      : in_data_byte XOR next keystream byte on out_byte
//     code 3 is dropped without effect.
//   Output channel (out_valid / out_stall) carries one out_byte per data item.
//   cfg_wr_en / cfg_wr_data set key_length (reset value 16); write only when idle.
// Sequencing (one shared 8-bit adder, one permutation RAM port each way):
//   key write     written straight into the key store; the block stays idle
//   data item     three permutation reads and two writes in sequence, then
//                 the result step; no new item is taken until the result
//                 has gone to the output register
//   start item    identity fill of 256 entries, then 256 schedule steps (K0-K3)
// Reset (synchronous, rst_n low) clears indices, sets key_length to 16 and
// then runs an identity fill of the 256-entry permutation; in_stall is high
// during that pass. A stalled result waits in the output register while the
// next item is taken; a second result waits in the sequencer until then.
module rc4_stream_cipher #(
  parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [7:0]                    in_key_index,
  input  wire logic [rc4_pkg::BYTE_W-1:0]    in_key_byte,
  input  wire logic [rc4_pkg::BYTE_W-1:0]    in_data_byte,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rc4_pkg::BYTE_W-1:0]         out_byte
);

  localparam int KIW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_r;
  logic                          out_valid_r;
  logic [rc4_pkg::BYTE_W-1:0]    out_byte_r;
  logic                          res_ready;
  rc4_pkg::res_t                 res;

  logic                          sbox_wr_en, sbox_rd_en;
  logic [7:0]                    sbox_wr_addr, sbox_rd_addr;
  logic [rc4_pkg::BYTE_W-1:0]    sbox_wr_data, sbox_rd_data;
  logic                          key_wr_en, key_rd_en;
  logic [KIW-1:0]                key_wr_addr, key_rd_addr;
  logic [rc4_pkg::BYTE_W-1:0]    key_wr_data, key_rd_data;

  // key length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_wr_en) begin
      key_length_r <= cfg_wr_data;
    end
  end

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  rc4_ctrl #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES),
    .KIW           (KIW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_key_byte  (in_key_byte),
    .in_data_byte (in_data_byte),
    .key_length   (key_length_r),
    .res_ready    (res_ready),
    .res          (res),
    .sbox_wr_en   (sbox_wr_en),
    .sbox_wr_addr (sbox_wr_addr),
    .sbox_wr_data (sbox_wr_data),
    .sbox_rd_en   (sbox_rd_en),
    .sbox_rd_addr (sbox_rd_addr),
    .sbox_rd_data (sbox_rd_data),
    .key_wr_en    (key_wr_en),
    .key_wr_addr  (key_wr_addr),
    .key_wr_data  (key_wr_data),
    .key_rd_en    (key_rd_en),
    .key_rd_addr  (key_rd_addr),
    .key_rd_data  (key_rd_data)
  );

  // permutation store
  rc4_ram #(
    .DEPTH (rc4_pkg::SBOX_DEPTH),
    .AW    (8),
    .DW    (rc4_pkg::BYTE_W)
  ) u_sbox (
    .clk     (clk),
    .wr_en   (sbox_wr_en),
    .wr_addr (sbox_wr_addr),
    .wr_data (sbox_wr_data),
    .rd_en   (sbox_rd_en),
    .rd_addr (sbox_rd_addr),
    .rd_data (sbox_rd_data)
  );

  // key store
  rc4_ram #(
    .DEPTH (KEY_MAX_BYTES),
    .AW    (KIW),
    .DW    (rc4_pkg::BYTE_W)
  ) u_key (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

endmodule

`default_nettype wire

FILE: bench/rc4_stream_cipher_tb.sv
// Testbench for rc4_stream_cipher: directed and random streams checked against a local RC4 predictor.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;

  // Code 3 is not defined by the package; the block drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Covers a whole start item: identity fill and key schedule.
  localparam int SCHED_CYCLES = 1400;
  // Receiver hold-off for the back-pressure test, long enough to fill the block.
  localparam int LONG_HOLD    = 150;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [8:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_key_index;
  logic [7:0] in_key_byte;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;

  // Predictor state: permutation, key store, generator indices, key length.
  logic [7:0] perm [256];
  logic [7:0] key_mem [256];
  bit         key_loaded [256];
  logic [7:0] ks_i;
  logic [7:0] ks_j;
  logic [8:0] key_len_reg;

  // Expected out_byte values, oldest first.
  logic [7:0] cipher_q [$];
  int         err_cnt = 0;

  // Idle controls shared by the sender, the receiver and the tests.
  bit src_idle_en   = 1'b0;
  bit sink_idle_en  = 1'b0;
  bit long_hold_req = 1'b0;

  rc4_stream_cipher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key_index (in_key_index),
    .in_key_byte  (in_key_byte),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Zero counts as one key byte, anything past 256 saturates.
  function automatic int sched_key_len();
    if (key_len_reg == '0) return 1;
    if (key_len_reg > 9'd256) return 256;
    return int'(key_len_reg);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Apply one transferred item to the predictor; data items queue an out_byte.
  function automatic void advance_cipher(input logic [1:0] op, input logic [7:0] kidx,
                                         input logic [7:0] kbyte, input logic [7:0] dbyte);
    int         len;
    logic [7:0] mix_j;
    logic [7:0] tmp;
    logic [7:0] ks_sum;
    unique case (op)
      rc4_pkg::OP_KEY_WRITE: begin
        key_mem[kidx]    = kbyte;
        key_loaded[kidx] = 1'b1;
      end
      rc4_pkg::OP_START: begin
        len = sched_key_len();
        for (int n = 0; n < 256; n++) perm[n] = 8'(n);
        mix_j = '0;
        for (int n = 0; n < 256; n++) begin
          mix_j       = mix_j + perm[n] + key_mem[n % len];
          tmp         = perm[n];
          perm[n]     = perm[mix_j];
          perm[mix_j] = tmp;
        end
        ks_i = '0;
        ks_j = '0;
      end
      rc4_pkg::OP_DATA: begin
        ks_i       = ks_i + 8'd1;
        ks_j       = ks_j + perm[ks_i];
        tmp        = perm[ks_i];
        perm[ks_i] = perm[ks_j];
        perm[ks_j] = tmp;
        ks_sum     = perm[ks_i] + perm[ks_j];
        cipher_q.push_back(dbyte ^ perm[ks_sum]);
      end
      default: ;  // unused code: no state change, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void check_out_byte(input logic [7:0] got);
    logic [7:0] want;
    if (cipher_q.size() == 0) begin
      err_cnt++;
      $display("%0t: out_byte %02h with nothing expected", $time, got);
    end else begin
      want = cipher_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, want, got);
      end
    end
  endfunction

  // Values seen here are the ones before this edge's updates.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      check_out_byte(out_byte);
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : out_stall_driver
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        hold = 0;
        while (hold < LONG_HOLD) begin
          @(posedge clk);
          hold++;
        end
        out_stall <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the transfer. Valid stays high afterwards
  // so back-to-back items need no second assignment in the same step.
  task automatic send_item(input logic [1:0] op, input logic [7:0] kidx,
                           input logic [7:0] kbyte, input logic [7:0] dbyte);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_index <= kidx;
    in_key_byte  <= kbyte;
    in_data_byte <= dbyte;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_cipher(op, kidx, kbyte, dbyte);
  endtask

  // Drop valid after the last transfer of a sequence.
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_data(input logic [7:0] dbyte);
    send_item(rc4_pkg::OP_DATA, rand_byte(), rand_byte(), dbyte);
  endtask

  // Load any key slot the schedule will read but that was never written, then start.
  task automatic start_message();
    int len;
    len = sched_key_len();
    for (int n = 0; n < len; n++)
      if (!key_loaded[n]) send_item(rc4_pkg::OP_KEY_WRITE, 8'(n), rand_byte(), rand_byte());
    send_item(rc4_pkg::OP_START, rand_byte(), rand_byte(), rand_byte());
  endtask

  // Write key_length only with the block idle: results drained and any
  // schedule in flight given time to finish.
  task automatic set_key_length(input logic [8:0] len);
    idle_input();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    key_len_reg = len;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Keystream straight from reset: identity permutation, indices at zero.
  // Also two unused codes in the middle of the stream.
  task automatic test_data_before_start();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_data(8'h00);
    send_data(8'hFF);
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    send_data(8'hA5);
    send_item(OP_UNUSED, 8'h00, 8'h00, 8'h00);
    send_data(8'h5A);
    idle_input();
  endtask

  // Receiver holds off while the sender keeps offering data, so the block
  // fills its result slots and must stall the input.
  task automatic test_output_backpressure();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    long_hold_req = 1'b1;
    for (int n = 0; n < 14; n++) send_data(rand_byte());
    idle_input();
  endtask

  // Key store extremes: first and last slot, all-zero and all-one bytes.
  task automatic test_key_extremes();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_item(rc4_pkg::OP_KEY_WRITE, 8'h00, 8'hFF, 8'h00);
    send_item(rc4_pkg::OP_KEY_WRITE, 8'hFF, 8'h00, 8'hFF);
    send_item(rc4_pkg::OP_KEY_WRITE, 8'h01, 8'h00, 8'h55);
    send_item(rc4_pkg::OP_KEY_WRITE, 8'h0F, 8'hFF, 8'hAA);
    start_message();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(rand_byte());
    // restart with the same key: stream must begin again
    start_message();
    send_data(8'h00);
    send_data(8'hFF);
    idle_input();
  endtask

  // key_length at one, the full store, zero (acts as one) and all ones
  // (saturates at the store size).
  task automatic test_key_length_extremes();
    logic [8:0] lens [4];
    lens = '{9'd1, 9'd256, 9'd0, 9'h1FF};
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    foreach (lens[k]) begin
      set_key_length(lens[k]);
      start_message();
      send_data(8'h00);
      send_data(rand_byte());
      send_data(8'hFF);
    end
    idle_input();
  endtask

  // Random messages: a key length per phase, fresh key bytes, a start, then
  // mostly data with key writes, unused codes and restarts mixed in.
  task automatic test_random_streams();
    int         r;
    logic [8:0] len;
    for (int p = 0; p < 3; p++) begin
      r = $urandom_range(0, 9);
      len = (r == 0) ? 9'($urandom_range(33, 256)) : 9'($urandom_range(1, 32));
      set_key_length(len);
      // last phase runs with no idling on either side
      src_idle_en  = (p < 2) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (p < 2) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(0, 8))
        send_item(rc4_pkg::OP_KEY_WRITE, 8'($urandom_range(0, int'(len) - 1)),
                  rand_byte(), rand_byte());
      start_message();
      repeat ($urandom_range(40, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          send_data(rand_byte());
        else if (r < 88)
          send_item(rc4_pkg::OP_KEY_WRITE, rand_byte(), rand_byte(), rand_byte());
        else if (r < 94)
          send_item(OP_UNUSED, rand_byte(), rand_byte(), rand_byte());
        else
          start_message();
      end
      idle_input();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // All block inputs known from time zero.
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_operation = rc4_pkg::OP_KEY_WRITE;
    in_key_index = '0;
    in_key_byte  = '0;
    in_data_byte = '0;
    out_stall    = 1'b0;

    // Predictor at its reset state.
    for (int n = 0; n < 256; n++) begin
      perm[n]       = 8'(n);
      key_mem[n]    = '0;
      key_loaded[n] = 1'b0;
    end
    ks_i        = '0;
    ks_j        = '0;
    key_len_reg = rc4_pkg::KEY_LEN_RESET;

    // Synchronous reset; the block's identity fill afterwards shows as in_stall.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_data_before_start();
    test_output_backpressure();
    test_key_extremes();
    test_key_length_extremes();
    test_random_streams();

    // Drain: every expected byte back, then room for a trailing schedule.
    idle_input();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SCHED_CYCLES) @(posedge clk);
    if (cipher_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d out_byte values never arrived", $time, cipher_q.size());
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
